/* hdl/dats_pkg.sv */
package dats_pkg;

  // table geometry
  localparam int NUM_TASKS = 16;
  localparam int MAX_DEPS  = 8;

  // field widths
  localparam int ID_W     = 4;
  localparam int PRIO_W   = 16;
  localparam int TSTATE_W = 3;
  localparam int MODE_W   = 3;
  localparam int STATUS_W = 2;

  localparam int TI_W     = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int DC_W     = $clog2(MAX_DEPS + 1);
  localparam int DEP_SPAN = 2 ** ID_W;

  typedef enum logic [MODE_W-1:0] {
    MODE_SET_STATE = 3'd0,
    MODE_SET_PRIO  = 3'd1,
    MODE_ADD_DEP   = 3'd2,
    MODE_REM_DEP   = 3'd3,
    MODE_REM_ALL   = 3'd4,
    MODE_GET_NEXT  = 3'd5
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_DONE      = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_NOT_FOUND = 2'd2
  } status_e;

  localparam logic [TSTATE_W-1:0] TS_INACTIVE = 3'd0;
  localparam logic [TSTATE_W-1:0] TS_FAILED   = 3'd4;
  localparam logic [TSTATE_W-1:0] TS_SUCCESS  = 3'd5;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_EXEC,
    CS_SCAN,
    CS_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [ID_W-1:0]   task_index;
    logic [ID_W-1:0]   dep_index;
    logic [PRIO_W-1:0] new_value;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0]     sel_task;
    logic [STATUS_W-1:0] status;
  } out_item_t;

  typedef logic [MAX_DEPS-1:0][ID_W-1:0] dep_row_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic scan;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_op;
    logic scan_last;
  } dp_sts_t;

endpackage

/* hdl/dats_ctrl.sv */
module dats_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  dats_pkg::dp_sts_t  sts_i,
  output dats_pkg::ctrl_cmd_t cmd_o
);
  import dats_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_vld_q, out_vld_d;
  logic        out_free;

  assign out_free = !out_vld_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      CS_IDLE: begin
        if (in_valid_i) state_d = CS_EXEC;
      end
      CS_EXEC: begin
        state_d = sts_i.scan_op ? CS_SCAN : CS_DONE;
      end
      CS_SCAN: begin
        if (sts_i.scan_last) state_d = CS_DONE;
      end
      CS_DONE: begin
        if (out_free) state_d = CS_IDLE;
      end
      default: state_d = CS_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      CS_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      CS_EXEC: cmd_o.exec = 1'b1;
      CS_SCAN: cmd_o.scan = 1'b1;
      CS_DONE: cmd_o.out_load = out_free;
      default: cmd_o = '0;
    endcase
  end

  always_comb begin
    if (cmd_o.out_load) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= CS_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign out_valid_o = out_vld_q;

endmodule

/* hdl/dats_dp.sv */
module dats_dp (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  dats_pkg::in_item_t        in_item_i,
  input  logic                      cfg_valid_i,
  input  logic [dats_pkg::ID_W-1:0] cfg_data_i,
  input  dats_pkg::ctrl_cmd_t       cmd_i,
  output dats_pkg::dp_sts_t         sts_o,
  output dats_pkg::out_item_t       out_item_o
);
  import dats_pkg::*;

  localparam logic [TI_W-1:0] LAST_TASK = TI_W'(NUM_TASKS - 1);

  in_item_t            item_q;
  logic [ID_W-1:0]     idle_q;

  logic [TSTATE_W-1:0] task_state_q [NUM_TASKS];
  logic [PRIO_W-1:0]   task_prio_q  [NUM_TASKS];
  logic [DC_W-1:0]     dep_cnt_q    [NUM_TASKS];

  dep_row_t            dep_mem [NUM_TASKS];
  dep_row_t            row_q;

  logic                iss_act_q, ev_vld_q;
  logic [TI_W-1:0]     rd_idx_q, ev_idx_q, last_idx_q;

  logic [ID_W-1:0]     best_q;
  logic [PRIO_W-1:0]   top_q;
  logic [STATUS_W-1:0] status_q;
  out_item_t           out_q;

  // decode of the held item
  logic            is_set_state, is_set_prio, is_add, is_rem, is_rem_all, is_next;
  logic            task_ok, dep_ok, scan_op, one_task;
  logic [TI_W-1:0] t_idx;

  assign is_set_state = item_q.mode == MODE_SET_STATE;
  assign is_set_prio  = item_q.mode == MODE_SET_PRIO;
  assign is_add       = item_q.mode == MODE_ADD_DEP;
  assign is_rem       = item_q.mode == MODE_REM_DEP;
  assign is_rem_all   = item_q.mode == MODE_REM_ALL;
  assign is_next      = item_q.mode == MODE_GET_NEXT;
  assign task_ok      = int'(item_q.task_index) < NUM_TASKS;
  assign dep_ok       = int'(item_q.dep_index) < NUM_TASKS;
  assign t_idx        = TI_W'(item_q.task_index);
  assign one_task     = is_rem || is_add;
  assign scan_op      = is_rem_all || is_next || (task_ok && (is_rem || (is_add && dep_ok)));

  assign sts_o.scan_op   = scan_op;
  assign sts_o.scan_last = ev_vld_q && (ev_idx_q == last_idx_q);

  // per-row evaluation of the task under test
  logic [DEP_SPAN-1:0] inactive_ext;
  logic [TSTATE_W-1:0] ev_state;
  logic [PRIO_W-1:0]   ev_prio;
  logic [DC_W-1:0]     ev_cnt;
  logic                blocked, eligible, full, hit;
  logic [MAX_DEPS-1:0] after;
  dep_row_t            add_row, rem_row, wr_row;
  logic                mem_we, ev_fire;

  always_comb begin
    for (int i = 0; i < DEP_SPAN; i++) begin
      inactive_ext[i] = 1'b0;
      if (i < NUM_TASKS) begin
        inactive_ext[i] = task_state_q[i] == TS_INACTIVE;
      end
    end
  end

  always_comb begin
    ev_state = task_state_q[ev_idx_q];
    ev_prio  = task_prio_q[ev_idx_q];
    ev_cnt   = dep_cnt_q[ev_idx_q];
    blocked  = 1'b0;
    hit      = 1'b0;
    for (int k = 0; k < MAX_DEPS; k++) begin
      if (k < int'(ev_cnt) && inactive_ext[row_q[k]]) blocked = 1'b1;
      if (k < int'(ev_cnt) && row_q[k] == item_q.dep_index) hit = 1'b1;
      after[k]   = hit;
      add_row[k] = (k == int'(ev_cnt)) ? item_q.dep_index : row_q[k];
    end
    // close the gap left by the first match
    for (int k = 0; k < MAX_DEPS - 1; k++) begin
      rem_row[k] = after[k] ? row_q[k+1] : row_q[k];
    end
    rem_row[MAX_DEPS-1] = row_q[MAX_DEPS-1];
    eligible = (ev_state != TS_FAILED) && (ev_state != TS_SUCCESS) && !blocked;
    full     = int'(ev_cnt) >= MAX_DEPS;
  end

  assign ev_fire = cmd_i.scan && ev_vld_q;
  assign mem_we  = ev_fire && ((is_add && !full) || ((is_rem || is_rem_all) && hit));
  assign wr_row  = is_add ? add_row : rem_row;

  always_ff @(posedge clk_i) begin
    if (mem_we) dep_mem[ev_idx_q] <= wr_row;
    row_q <= dep_mem[rd_idx_q];
  end

  // task table
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_TASKS; i++) begin
        task_state_q[i] <= TS_INACTIVE;
        task_prio_q[i]  <= '0;
        dep_cnt_q[i]    <= '0;
      end
      idle_q <= '0;
    end else begin
      if (cfg_valid_i) idle_q <= cfg_data_i;
      if (cmd_i.exec && !scan_op && task_ok) begin
        if (is_set_state) task_state_q[t_idx] <= item_q.new_value[TSTATE_W-1:0];
        if (is_set_prio)  task_prio_q[t_idx]  <= item_q.new_value;
      end
      if (mem_we) begin
        dep_cnt_q[ev_idx_q] <= is_add ? ev_cnt + DC_W'(1) : ev_cnt - DC_W'(1);
      end
    end
  end

  // scan sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iss_act_q <= 1'b0;
      ev_vld_q  <= 1'b0;
    end else if (cmd_i.exec) begin
      iss_act_q <= scan_op;
      ev_vld_q  <= 1'b0;
    end else if (cmd_i.scan) begin
      ev_vld_q <= iss_act_q;
      if (iss_act_q && rd_idx_q == last_idx_q) iss_act_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) item_q <= in_item_i;
    if (cmd_i.exec) begin
      rd_idx_q   <= one_task ? t_idx : '0;
      last_idx_q <= one_task ? t_idx : LAST_TASK;
      best_q     <= is_next ? idle_q : '0;
      top_q      <= '0;
      status_q   <= is_rem_all ? STATUS_NOT_FOUND : STATUS_DONE;
    end else if (cmd_i.scan) begin
      if (iss_act_q) begin
        ev_idx_q <= rd_idx_q;
        if (rd_idx_q != last_idx_q) rd_idx_q <= rd_idx_q + TI_W'(1);
      end
      if (ev_vld_q) begin
        if (is_next && eligible && ev_prio > top_q) begin
          top_q  <= ev_prio;
          best_q <= ID_W'(ev_idx_q);
        end
        if (is_add) status_q <= full ? STATUS_FULL : STATUS_DONE;
        if (is_rem) status_q <= hit ? STATUS_DONE : STATUS_NOT_FOUND;
        if (is_rem_all && hit) status_q <= STATUS_DONE;
      end
    end
    if (cmd_i.out_load) begin
      out_q.sel_task <= best_q;
      out_q.status   <= status_q;
    end
  end

  assign out_item_o = out_q;

endmodule

/* hdl/dependency_aware_task_selector_unit.sv */
// Channel   Direction  Handshake                Payload
// in        input      in_valid_i / in_ready_o  in_item_i  (in_item_t)
// out       output     out_valid_o / out_ready_i out_item_o (out_item_t)
// cfg       input      cfg_valid_i / cfg_ready_o cfg_data_i (idle task)
//
// One item at a time. Set state, set priority, unused modes and rejected dependency
// ops go straight from the execute state to the result state, with no scan. Add/remove
// on one task scans only that task's row (one dependency row read, then written back).
// Remove everywhere and get next scan every task row, one row per cycle. Reset clears the
// task table; the dependency memory is not cleared. A stalled output holds its item,
// the next item then waits in the last stage and the input stays blocked until it drains.
module dependency_aware_task_selector_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  dats_pkg::in_item_t        in_item_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output dats_pkg::out_item_t       out_item_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [dats_pkg::ID_W-1:0] cfg_data_i
);
  import dats_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  assign cfg_ready_o = 1'b1;

  dats_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  dats_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_item_o  (out_item_o)
  );

  // never overwrite a result that has not been taken
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.out_load && out_valid_o) |-> out_ready_i)
    else $error("result overwritten before it was taken");

  // an accepted item keeps the block busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input ready right after accept");

  // scan completion is followed by the result stage, still busy and no longer scanning
  a_scan_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.scan && sts.scan_last) |=> (!in_ready_o && !cmd.scan))
    else $error("scan end not followed by result stage");

endmodule
